// ----- rtl/core/gdfs_pkg.sv -----
// Shared types and constants for the GPS decimal field scanner.
`timescale 1ns / 1ps
`default_nettype none

package gdfs_pkg;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2
  } scan_phase_t;

  localparam logic [1:0] FIELD_TIME = 2'd0;
  localparam logic [1:0] FIELD_LAT  = 2'd1;
  localparam logic [1:0] FIELD_LON  = 2'd2;

  localparam logic [1:0] CFG_TIME_DIGITS = 2'd0;
  localparam logic [1:0] CFG_POS_MIN     = 2'd1;
  localparam logic [1:0] CFG_POS_MAX     = 2'd2;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [29:0] VALUE_CEILING = 30'd999999999;
  localparam logic [4:0]  DIGIT_SAT     = 5'd31;
  localparam logic [3:0]  FRAC_CNT_SAT  = 4'd15;

  // Largest value a part may hold: 10^digits - 1, clipped to nine nines.
  function automatic logic [29:0] part_cap(input int digits);
    longint cap;
    int     i;
    cap = 1;
    for (i = 0; i < digits && i < 18; i++) begin
      cap = cap * 10;
    end
    cap = cap - 1;
    if (cap > 64'(VALUE_CEILING)) begin
      cap = 64'(VALUE_CEILING);
    end
    return cap[29:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gps_decimal_field_scanner_core.sv -----
// GPS decimal field scanner: character stage, scan state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Scans a GPS character stream one word (character) per cycle. Non-digits are
// skipped; a run of integer digits, an optional '.', and fraction digits form
// one number, which ends at the first character that cannot continue it (that
// character is consumed). Each finished number yields one result word with the
// integer value, the fraction value and its digit count, the total digit count,
// an overflow flag (a part passed MAX_PART_DIGITS digits or nine nines, value
// saturates), the field it belongs to (time, latitude, longitude, cycling), and
// an accepted flag: time needs exactly time_digit_count digits, a position
// needs a count in [position_digits_min, position_digits_max]. resync with a
// character forces the field back to time before that character is handled.
// Throughput is one character per clock, sustained. An accepted character sits
// in a one-word input stage and is folded into the scan state when it leaves
// the stage (one multiply-by-ten accumulate per part); a number it ends is
// loaded into the output register at that same edge. The stage keeps taking
// characters while a result waits, and stalls only when a terminating
// character meets a full output register. Configuration registers (index 0
// time count, 1 position min, 2 position max) are written through cfg_we /
// cfg_index / cfg_data by the user while idle; the block does not enforce it.
module gps_decimal_field_scanner_core #(
  parameter int MAX_PART_DIGITS = 9
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // character input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char,
  input  wire logic        resync,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       field_index,
  output logic [29:0]      whole_part,
  output logic [29:0]      fraction_value,
  output logic [3:0]       fraction_digits,
  output logic [4:0]       digit_total,
  output logic             accepted,
  output logic             overflow,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  localparam logic [29:0] PART_CAP  = gdfs_pkg::part_cap(MAX_PART_DIGITS);
  localparam logic [4:0]  MAX_DIGITS = 5'(MAX_PART_DIGITS);
  localparam logic [33:0] CEIL_WIDE = 34'(gdfs_pkg::VALUE_CEILING);

  // configuration registers
  logic [3:0] time_digit_count;
  logic [3:0] position_digits_min;
  logic [3:0] position_digits_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_digit_count    <= 4'd9;
      position_digits_min <= 4'd7;
      position_digits_max <= 4'd9;
    end else if (cfg_we) begin
      case (cfg_index)
        gdfs_pkg::CFG_TIME_DIGITS: time_digit_count    <= cfg_data;
        gdfs_pkg::CFG_POS_MIN:     position_digits_min <= cfg_data;
        gdfs_pkg::CFG_POS_MAX:     position_digits_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: one character word
  logic       stage_valid;
  logic [7:0] stage_char;
  logic       stage_resync;
  logic       stage_adv;

  // scan state
  gdfs_pkg::scan_phase_t scan_phase, scan_phase_next;
  logic [1:0]  current_field, current_field_next;
  logic [29:0] whole_acc, whole_acc_next;
  logic [29:0] fraction_acc, fraction_acc_next;
  logic [3:0]  fraction_count, fraction_count_next;
  logic [4:0]  digit_count, digit_count_next;
  logic        overflow_seen, overflow_seen_next;

  // per-character decode
  logic        is_digit;
  logic [3:0]  digit_val;
  logic        emit;
  logic        field_ok;
  logic [1:0]  field_now;
  logic [33:0] whole_push;
  logic [33:0] frac_push;
  logic        whole_ovf;
  logic        frac_ovf;
  logic        frac_inc;
  logic [4:0]  digit_count_inc;
  logic        out_free;

  assign is_digit  = (stage_char >= gdfs_pkg::CH_ZERO) && (stage_char <= gdfs_pkg::CH_NINE);
  assign digit_val = stage_char[3:0];

  // ASCII digits carry their value in the low nibble
  assign whole_push = 34'(whole_acc) * 34'd10 + 34'(digit_val);
  assign frac_push  = 34'(fraction_acc) * 34'd10 + 34'(digit_val);

  assign whole_ovf = (digit_count >= MAX_DIGITS) || (whole_push > CEIL_WIDE);
  assign frac_ovf  = ({1'b0, fraction_count} >= MAX_DIGITS) || (frac_push > CEIL_WIDE);
  // fraction count holds when the part is full, or when this digit just clipped it
  assign frac_inc  = ({1'b0, fraction_count} < MAX_DIGITS)
                     && !((frac_push > CEIL_WIDE) && (fraction_acc != PART_CAP))
                     && (fraction_count != gdfs_pkg::FRAC_CNT_SAT);

  assign digit_count_inc = (digit_count == gdfs_pkg::DIGIT_SAT) ? digit_count
                                                                : digit_count + 5'd1;

  always_comb begin
    emit = 1'b0;
    case (scan_phase)
      gdfs_pkg::PH_INT:  emit = !is_digit && (stage_char != gdfs_pkg::CH_DOT);
      gdfs_pkg::PH_FRAC: emit = !is_digit;
      default:           emit = 1'b0;
    endcase
  end

  // resync and unused code 3 both mean time
  assign field_now = (stage_resync || (current_field == 2'd3)) ? gdfs_pkg::FIELD_TIME
                                                                 : current_field;

  always_comb begin
    if (field_now == gdfs_pkg::FIELD_TIME) begin
      field_ok = (digit_count == {1'b0, time_digit_count});
    end else begin
      field_ok = (digit_count >= {1'b0, position_digits_min})
                 && (digit_count <= {1'b0, position_digits_max});
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign stage_adv = stage_valid && (!emit || out_free);
  assign in_ready  = !stage_valid || stage_adv;

  // next scan state
  always_comb begin
    scan_phase_next     = scan_phase;
    current_field_next  = field_now;
    whole_acc_next      = whole_acc;
    fraction_acc_next   = fraction_acc;
    fraction_count_next = fraction_count;
    digit_count_next    = digit_count;
    overflow_seen_next  = overflow_seen;
    if (emit) begin
      scan_phase_next     = gdfs_pkg::PH_SKIP;
      current_field_next  = (field_now == gdfs_pkg::FIELD_LON) ? gdfs_pkg::FIELD_TIME
                                                               : field_now + 2'd1;
      whole_acc_next      = '0;
      fraction_acc_next   = '0;
      fraction_count_next = '0;
      digit_count_next    = '0;
      overflow_seen_next  = 1'b0;
    end else begin
      case (scan_phase)
        gdfs_pkg::PH_INT: begin
          if (is_digit) begin
            whole_acc_next     = whole_ovf ? PART_CAP : whole_push[29:0];
            overflow_seen_next = overflow_seen || whole_ovf;
            digit_count_next   = digit_count_inc;
          end else begin
            scan_phase_next = gdfs_pkg::PH_FRAC;
          end
        end
        gdfs_pkg::PH_FRAC: begin
          fraction_acc_next   = frac_ovf ? PART_CAP : frac_push[29:0];
          overflow_seen_next  = overflow_seen || frac_ovf;
          fraction_count_next = frac_inc ? fraction_count + 4'd1 : fraction_count;
          digit_count_next    = digit_count_inc;
        end
        default: begin
          if (is_digit) begin
            scan_phase_next  = gdfs_pkg::PH_INT;
            whole_acc_next   = 30'(digit_val);
            digit_count_next = 5'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_char   <= in_char;
      stage_resync <= resync;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase     <= gdfs_pkg::PH_SKIP;
      current_field  <= gdfs_pkg::FIELD_TIME;
      whole_acc      <= '0;
      fraction_acc   <= '0;
      fraction_count <= '0;
      digit_count    <= '0;
      overflow_seen  <= 1'b0;
    end else if (stage_adv) begin
      scan_phase     <= scan_phase_next;
      current_field  <= current_field_next;
      whole_acc      <= whole_acc_next;
      fraction_acc   <= fraction_acc_next;
      fraction_count <= fraction_count_next;
      digit_count    <= digit_count_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && emit) begin
      field_index     <= field_now;
      whole_part      <= whole_acc;
      fraction_value  <= fraction_acc;
      fraction_digits <= fraction_count;
      digit_total     <= digit_count;
      accepted        <= field_ok;
      overflow        <= overflow_seen;
    end
  end

`ifndef SYNTH
  // skip phase always starts from a cleared number
  a_skip_clear: assert property (@(posedge clk) disable iff (rst)
    scan_phase == gdfs_pkg::PH_SKIP |-> digit_count == 5'd0 && fraction_count == 4'd0
                                        && !overflow_seen)
    else $error("scan state not cleared in skip phase");

  // a held character word is never dropped
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_adv |=> stage_valid && $stable(stage_char))
    else $error("stalled character word lost");

  // fraction digits are part of the total
  a_frac_le_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, fraction_digits} <= digit_total)
    else $error("fraction digit count exceeds total");

  // a terminator never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(stage_adv && emit))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
